// ===== design/pcsi_pkg.sv =====
// Shared types, widths and helper functions for the point comparison step interpolator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcsi_pkg;

  localparam int COORD_BITS = 24;
  localparam int DISP_BITS  = COORD_BITS + 1;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int REM_BITS   = COORD_BITS + 2;
  localparam int DEV_BITS   = 2 * COORD_BITS + 4;
  localparam int DELTA_BITS = COORD_BITS + 3;
  localparam int PERIM_BITS = COORD_BITS + 4;
  localparam int SPAN_BITS  = COORD_BITS + 6;

  localparam int IN_FIELDS_W = 6 * COORD_BITS + RAD_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W   = 2;
  localparam int OUT_FIELDS_W = 4 + 2 * COORD_BITS + REM_BITS + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int OB_STEP_X = 0;
  localparam int OB_STEP_Y = 1;
  localparam int OB_DIR_X  = 2;
  localparam int OB_DIR_Y  = 3;
  localparam int OB_POS_X  = 4;
  localparam int OB_POS_Y  = OB_POS_X + COORD_BITS;
  localparam int OB_LEFT   = OB_POS_Y + COORD_BITS;
  localparam int OB_BUSY   = OB_LEFT + REM_BITS;
  localparam int OB_MISSED = OB_BUSY + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DISP_BITS-1:0]  disp_t;
  typedef logic        [RAD_BITS-1:0]   rad_t;
  typedef logic        [REM_BITS-1:0]   rem_t;
  typedef logic signed [DEV_BITS-1:0]   dev_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [PERIM_BITS-1:0] perim_t;
  typedef logic signed [SPAN_BITS-1:0]  span_t;

  localparam rem_t REM_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LINE    = 2'd0,
    CMD_ARC_CCW = 2'd1,
    CMD_ARC_CW  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    QUAD_NONE = 3'd0,
    QUAD_1    = 3'd1,
    QUAD_2    = 3'd2,
    QUAD_3    = 3'd3,
    QUAD_4    = 3'd4
  } quad_t;

  typedef struct packed {
    cmd_t   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t ctr_x;
    coord_t ctr_y;
    disp_t  disp_x;
    disp_t  disp_y;
    rem_t   line_len;
    perim_t perim_s;
    perim_t perim_e;
    span_t  rad8;
  } req_t;

  typedef struct packed {
    logic   step_x;
    logic   step_y;
    logic   dir_x;
    logic   dir_y;
    coord_t pos_x;
    coord_t pos_y;
    rem_t   steps_left;
    logic   busy;
    logic   missed;
  } result_t;

  // Quadrant with the axes assigned for counter-clockwise travel and for lines.
  function automatic quad_t quad_ccw(disp_t u, disp_t v);
    quad_t q;
    if (u > 0 && v >= 0) begin
      q = QUAD_1;
    end else if (u <= 0 && v > 0) begin
      q = QUAD_2;
    end else if (u < 0 && v <= 0) begin
      q = QUAD_3;
    end else if (u >= 0 && v < 0) begin
      q = QUAD_4;
    end else begin
      q = QUAD_NONE;
    end
    return q;
  endfunction

  // Quadrant with the axes assigned for clockwise travel.
  function automatic quad_t quad_cw(disp_t u, disp_t v);
    quad_t q;
    if (u >= 0 && v > 0) begin
      q = QUAD_1;
    end else if (u < 0 && v >= 0) begin
      q = QUAD_2;
    end else if (u <= 0 && v < 0) begin
      q = QUAD_3;
    end else if (u > 0 && v <= 0) begin
      q = QUAD_4;
    end else begin
      q = QUAD_NONE;
    end
    return q;
  endfunction

  // Position of (u, v) along the quadrant perimeter map of radius r.
  function automatic perim_t perim(disp_t u, disp_t v, rad_t r, logic cw);
    perim_t pu;
    perim_t pv;
    perim_t r1;
    perim_t r3;
    perim_t r5;
    perim_t r7;
    perim_t p;
    pu = perim_t'(u);
    pv = perim_t'(v);
    r1 = perim_t'(r);
    r3 = (r1 <<< 1) + r1;
    r5 = (r1 <<< 2) + r1;
    r7 = (r1 <<< 3) - r1;
    p  = '0;
    if (!cw) begin
      unique case (quad_ccw(u, v))
        QUAD_1:  p = r1 - pu + pv;
        QUAD_2:  p = r3 - pu - pv;
        QUAD_3:  p = r5 + pu - pv;
        QUAD_4:  p = r7 + pu + pv;
        default: p = '0;
      endcase
    end else begin
      unique case (quad_cw(u, v))
        QUAD_1:  p = r7 + pu - pv;
        QUAD_2:  p = r5 + pu + pv;
        QUAD_3:  p = r3 - pu + pv;
        QUAD_4:  p = r1 - pu - pv;
        default: p = '0;
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcsi_load_prep.sv =====
// Request decode ahead of the input register: displacement, line length and arc perimeters.
// Depends on pcsi_pkg for types and the quadrant and perimeter functions.
`timescale 1ns / 1ps
`default_nettype none

module pcsi_load_prep (
  input  pcsi_pkg::cmd_t   cmd,
  input  pcsi_pkg::coord_t start_x,
  input  pcsi_pkg::coord_t start_y,
  input  pcsi_pkg::coord_t end_x,
  input  pcsi_pkg::coord_t end_y,
  input  pcsi_pkg::coord_t center_x,
  input  pcsi_pkg::coord_t center_y,
  input  pcsi_pkg::rad_t   radius,
  output pcsi_pkg::req_t   req
);
  import pcsi_pkg::*;

  disp_t dx;
  disp_t dy;
  disp_t su;
  disp_t sv;
  disp_t eu;
  disp_t ev;
  logic [DISP_BITS-1:0] ax;
  logic [DISP_BITS-1:0] ay;
  logic cw;

  always_comb begin
    dx = disp_t'(end_x) - disp_t'(start_x);
    dy = disp_t'(end_y) - disp_t'(start_y);
    su = disp_t'(start_x) - disp_t'(center_x);
    sv = disp_t'(start_y) - disp_t'(center_y);
    eu = disp_t'(end_x) - disp_t'(center_x);
    ev = disp_t'(end_y) - disp_t'(center_y);
    ax = dx[DISP_BITS-1] ? DISP_BITS'(-dx) : DISP_BITS'(dx);
    ay = dy[DISP_BITS-1] ? DISP_BITS'(-dy) : DISP_BITS'(dy);
    cw = (cmd == CMD_ARC_CW);

    req.cmd      = cmd;
    req.start_x  = start_x;
    req.start_y  = start_y;
    req.end_x    = end_x;
    req.end_y    = end_y;
    req.ctr_x    = center_x;
    req.ctr_y    = center_y;
    req.disp_x   = dx;
    req.disp_y   = dy;
    req.line_len = rem_t'(ax) + rem_t'(ay);
    req.perim_s  = perim(su, sv, radius, cw);
    req.perim_e  = perim(eu, ev, radius, cw);
    req.rad8     = span_t'(radius) <<< 3;
  end

endmodule

`default_nettype wire

// ===== design/pcsi_step_core.sv =====
// Move state and the per-request step decision: load setup, line and arc comparison steps.
// Depends on pcsi_pkg for types, widths and the quadrant functions.
`timescale 1ns / 1ps
`default_nettype none

module pcsi_step_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  pcsi_pkg::req_t    req,
  output pcsi_pkg::result_t res
);
  import pcsi_pkg::*;

  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  dev_t   dev_r, dev_nxt;
  rem_t   rem_r, rem_nxt;
  cmd_t   kind_r, kind_nxt;
  disp_t  disp_x_r, disp_x_nxt;
  disp_t  disp_y_r, disp_y_nxt;
  coord_t tgt_x_r, tgt_x_nxt;
  coord_t tgt_y_r, tgt_y_nxt;
  coord_t ctr_x_r, ctr_x_nxt;
  coord_t ctr_y_r, ctr_y_nxt;
  logic   active_r, active_nxt;

  logic   sx;
  logic   sy;
  logic   xp;
  logic   yp;
  logic   neg;
  disp_t  u;
  disp_t  v;
  quad_t  q;
  delta_t delta;
  delta_t two_u;
  delta_t two_v;
  span_t  span;

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    dev_nxt    = dev_r;
    rem_nxt    = rem_r;
    kind_nxt   = kind_r;
    disp_x_nxt = disp_x_r;
    disp_y_nxt = disp_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    ctr_x_nxt  = ctr_x_r;
    ctr_y_nxt  = ctr_y_r;
    active_nxt = active_r;
    sx    = 1'b0;
    sy    = 1'b0;
    xp    = 1'b0;
    yp    = 1'b0;
    delta = '0;
    neg   = dev_r[DEV_BITS-1];
    u     = disp_t'(cur_x_r) - disp_t'(ctr_x_r);
    v     = disp_t'(cur_y_r) - disp_t'(ctr_y_r);
    two_u = delta_t'(u) <<< 1;
    two_v = delta_t'(v) <<< 1;
    q     = (kind_r == CMD_ARC_CW) ? quad_cw(u, v) : quad_ccw(u, v);

    if (req.perim_e >= req.perim_s) begin
      span = span_t'(req.perim_e) - span_t'(req.perim_s);
    end else begin
      span = req.rad8 - span_t'(req.perim_s) + span_t'(req.perim_e);
    end

    if (step_en) begin
      if (req.cmd != CMD_TICK) begin
        cur_x_nxt  = req.start_x;
        cur_y_nxt  = req.start_y;
        tgt_x_nxt  = req.end_x;
        tgt_y_nxt  = req.end_y;
        ctr_x_nxt  = req.ctr_x;
        ctr_y_nxt  = req.ctr_y;
        disp_x_nxt = req.disp_x;
        disp_y_nxt = req.disp_y;
        dev_nxt    = '0;
        kind_nxt   = req.cmd;
        if (req.cmd == CMD_LINE) begin
          rem_nxt = req.line_len;
        end else if (span[SPAN_BITS-1]) begin
          rem_nxt = '0;
        end else if (span > span_t'(REM_MAX)) begin
          rem_nxt = REM_MAX;
        end else begin
          rem_nxt = span[REM_BITS-1:0];
        end
        active_nxt = (rem_nxt != '0);
      end else if (active_r) begin
        if (kind_r == CMD_LINE) begin
          unique case (quad_ccw(disp_x_r, disp_y_r))
            QUAD_1: begin
              if (!neg) begin
                sx = 1'b1; xp = 1'b1; delta = -delta_t'(disp_y_r);
              end else begin
                sy = 1'b1; yp = 1'b1; delta = delta_t'(disp_x_r);
              end
            end
            QUAD_2: begin
              if (neg) begin
                sx = 1'b1; delta = delta_t'(disp_y_r);
              end else begin
                sy = 1'b1; yp = 1'b1; delta = delta_t'(disp_x_r);
              end
            end
            QUAD_3: begin
              if (neg) begin
                sy = 1'b1; delta = -delta_t'(disp_x_r);
              end else begin
                sx = 1'b1; delta = delta_t'(disp_y_r);
              end
            end
            QUAD_4: begin
              if (!neg) begin
                sy = 1'b1; delta = -delta_t'(disp_x_r);
              end else begin
                sx = 1'b1; xp = 1'b1; delta = -delta_t'(disp_y_r);
              end
            end
            default: begin
            end
          endcase
        end else begin
          if (kind_r == CMD_ARC_CW) begin
            unique case (q)
              QUAD_1: begin
                if (neg) begin sx = 1'b1; xp = 1'b1; end else begin sy = 1'b1; end
              end
              QUAD_2: begin
                if (neg) begin sy = 1'b1; yp = 1'b1; end else begin sx = 1'b1; xp = 1'b1; end
              end
              QUAD_3: begin
                if (neg) begin sx = 1'b1; end else begin sy = 1'b1; yp = 1'b1; end
              end
              QUAD_4: begin
                if (neg) begin sy = 1'b1; end else begin sx = 1'b1; end
              end
              default: begin
              end
            endcase
          end else begin
            unique case (q)
              QUAD_1: begin
                if (neg) begin sy = 1'b1; yp = 1'b1; end else begin sx = 1'b1; end
              end
              QUAD_2: begin
                if (neg) begin sx = 1'b1; end else begin sy = 1'b1; end
              end
              QUAD_3: begin
                if (neg) begin sy = 1'b1; end else begin sx = 1'b1; xp = 1'b1; end
              end
              QUAD_4: begin
                if (neg) begin sx = 1'b1; xp = 1'b1; end else begin sy = 1'b1; yp = 1'b1; end
              end
              default: begin
              end
            endcase
          end
          if (sx) begin
            delta = xp ? (two_u + delta_t'(1)) : (delta_t'(1) - two_u);
          end else if (sy) begin
            delta = yp ? (two_v + delta_t'(1)) : (delta_t'(1) - two_v);
          end
        end

        dev_nxt = dev_r + dev_t'(delta);
        if (sx) begin
          cur_x_nxt = xp ? (cur_x_r + coord_t'(1)) : (cur_x_r - coord_t'(1));
        end
        if (sy) begin
          cur_y_nxt = yp ? (cur_y_r + coord_t'(1)) : (cur_y_r - coord_t'(1));
        end
        rem_nxt = rem_r - rem_t'(1);
        if (kind_r != CMD_LINE && cur_x_nxt == tgt_x_r && cur_y_nxt == tgt_y_r) begin
          rem_nxt = '0;
        end
        active_nxt = (rem_nxt != '0);
      end
    end

    res.step_x     = sx;
    res.step_y     = sy;
    res.dir_x      = sx & xp;
    res.dir_y      = sy & yp;
    res.pos_x      = cur_x_nxt;
    res.pos_y      = cur_y_nxt;
    res.steps_left = rem_nxt;
    res.busy       = active_nxt;
    res.missed     = !active_nxt && (cur_x_nxt != tgt_x_nxt || cur_y_nxt != tgt_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      dev_r    <= '0;
      rem_r    <= '0;
      kind_r   <= CMD_LINE;
      disp_x_r <= '0;
      disp_y_r <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      ctr_x_r  <= '0;
      ctr_y_r  <= '0;
      active_r <= 1'b0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      dev_r    <= dev_nxt;
      rem_r    <= rem_nxt;
      kind_r   <= kind_nxt;
      disp_x_r <= disp_x_nxt;
      disp_y_r <= disp_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      ctr_x_r  <= ctr_x_nxt;
      ctr_y_r  <= ctr_y_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/point_compare_step_interpolator_unit.sv =====
// Top level of the two-axis point comparison step interpolator: input and result registers.
// Depends on pcsi_pkg, pcsi_load_prep and pcsi_step_core.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------------------
//   in      | in_tvalid in_tready in_tdata   | one load or tick request
//           | in_tuser                       | command
//   out     | out_tvalid out_tready out_tdata| one result per request
//
// A request is registered in the input register on acceptance, and its result is registered
// in the result register when it advances, which waits while a stalled result is held.
// One request is taken each cycle while the output is not stalled.
// Reset clears the move state to an idle line at the origin and empties both registers.
// A stalled result holds in the result register while the input register takes one more
// request; further requests wait until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module point_compare_step_interpolator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
  input  logic [pcsi_pkg::IN_DATA_W-1:0]    in_tdata,
  // command
  input  logic [pcsi_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // step_x, step_y, dir_x, dir_y, pos_x, pos_y, steps_left, busy_res, endpoint_missed
  output logic [pcsi_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import pcsi_pkg::*;

  req_t    req;
  req_t    req_r;
  result_t res;
  result_t res_r;
  logic    req_valid_r, req_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    in_fire;
  logic    advance;

  pcsi_load_prep u_prep (
    .cmd      (cmd_t'(in_tuser)),
    .start_x  (coord_t'(in_tdata[COORD_BITS-1:0])),
    .start_y  (coord_t'(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .end_x    (coord_t'(in_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .end_y    (coord_t'(in_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .center_x (coord_t'(in_tdata[5*COORD_BITS-1:4*COORD_BITS])),
    .center_y (coord_t'(in_tdata[6*COORD_BITS-1:5*COORD_BITS])),
    .radius   (rad_t'(in_tdata[IN_FIELDS_W-1:6*COORD_BITS])),
    .req      (req)
  );

  pcsi_step_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .req     (req_r),
    .res     (res)
  );

  always_comb begin
    advance       = req_valid_r && (!out_valid_r || out_tready);
    in_tready     = !req_valid_r || advance;
    in_fire       = in_tvalid && in_tready;
    req_valid_nxt = in_fire || (req_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= req;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({res_r.missed, res_r.busy, res_r.steps_left,
                                   res_r.pos_y, res_r.pos_x, res_r.dir_y, res_r.dir_x,
                                   res_r.step_y, res_r.step_x});

endmodule

`default_nettype wire

// ===== design/pcsi_checker.sv =====
// Port-level checks for the step interpolator top level, attached by a bind statement.
// Depends on pcsi_pkg for the result field positions.
`timescale 1ns / 1ps
`default_nettype none

module pcsi_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [pcsi_pkg::OUT_DATA_W-1:0] out_tdata
);
  import pcsi_pkg::*;

  logic step_x;
  logic step_y;
  logic dir_x;
  logic dir_y;
  logic busy;
  logic missed;
  rem_t left;

  assign step_x = out_tdata[OB_STEP_X];
  assign step_y = out_tdata[OB_STEP_Y];
  assign dir_x  = out_tdata[OB_DIR_X];
  assign dir_y  = out_tdata[OB_DIR_Y];
  assign busy   = out_tdata[OB_BUSY];
  assign missed = out_tdata[OB_MISSED];
  assign left   = out_tdata[OB_LEFT +: REM_BITS];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(step_x && step_y))
    else $error("Both axes stepped in one tick.");

  a_dir_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!dir_x || step_x) && (!dir_y || step_y))
    else $error("Direction set on an axis that did not step.");

  a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (busy == (left != '0)))
    else $error("Busy flag disagrees with the remaining step count.");

  a_missed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && missed |-> !busy)
    else $error("Endpoint miss reported while a move is running.");

endmodule

bind point_compare_step_interpolator_unit pcsi_checker u_pcsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
